FILE: rtl/knock_detector_interval_recorder_core_defines.svh
// ----------------------------------------------------------------------------
// Knock detector assertion macros
// Shared concurrent assertion forms, clocked on clk and held off in reset.
// ----------------------------------------------------------------------------
`ifndef KNOCK_DETECTOR_INTERVAL_RECORDER_CORE_DEFINES_SVH
`define KNOCK_DETECTOR_INTERVAL_RECORDER_CORE_DEFINES_SVH

// Same-cycle implication
`define KDIR_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication
`define KDIR_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: rtl/kdir_pkg.sv
// ----------------------------------------------------------------------------
// Knock detector package
// Widths, register indexes, reset values and shared types.
// ----------------------------------------------------------------------------
package kdir_pkg;

  localparam int ACCEL_W  = 13;
  localparam int SQ_W     = 26;
  localparam int TIME_W   = 32;
  localparam int MS_W     = 16;
  localparam int COUNT_W  = 8;
  localparam int CFG_W    = 26;
  localparam int CFG_IDX_W = 3;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_UPPER_SQ    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_LOWER_SQ    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_DEBOUNCE    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_IDLE        = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_KNOCK_QUOTA = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_KNOCK_CAP   = 3'd5;

  // reset values (1.15 g and 0.85 g squared, in counts^2)
  localparam logic [SQ_W-1:0]    RST_UPPER_SQ    = 26'd86949;
  localparam logic [SQ_W-1:0]    RST_LOWER_SQ    = 26'd47502;
  localparam logic [MS_W-1:0]    RST_DEBOUNCE    = 16'd120;
  localparam logic [MS_W-1:0]    RST_IDLE        = 16'd5000;
  localparam logic [COUNT_W-1:0] RST_KNOCK_QUOTA = 8'd5;
  localparam logic [COUNT_W-1:0] RST_KNOCK_CAP   = 8'd30;

  localparam logic OP_START  = 1'b0;
  localparam logic OP_SAMPLE = 1'b1;

  typedef enum logic [1:0] {
    STATUS_IDLE    = 2'd0,
    STATUS_SUCCESS = 2'd1,
    STATUS_TOO_FEW = 2'd2
  } status_t;

  typedef struct packed {
    logic [SQ_W-1:0]    upper_sq;
    logic [SQ_W-1:0]    lower_sq;
    logic [MS_W-1:0]    debounce_ms;
    logic [MS_W-1:0]    idle_ms;
    logic [COUNT_W-1:0] knock_quota;
    logic [COUNT_W-1:0] knock_cap;
  } cfg_t;

  typedef struct packed {
    logic               recording;
    logic [TIME_W-1:0]  last_knock_time;
    logic [COUNT_W-1:0] knock_count;
  } state_t;

  typedef struct packed {
    logic               knock_seen;
    logic               knock_recorded;
    logic [COUNT_W-1:0] knock_number;
    logic               interval_valid;
    logic [TIME_W-1:0]  interval_ms;
    logic               finished;
    status_t            status;
  } result_t;

endpackage

FILE: rtl/knock_detector_interval_recorder_core.sv
// ----------------------------------------------------------------------------
// Knock detector interval recorder
// Tap detection on squared accelerometer magnitude with debounce, interval
// logging and idle timeout.
// ----------------------------------------------------------------------------
//  channel | dir | handshake            | payload
//  in_     | in  | in_valid / in_ready   | op, accel_x/y/z, time_ms
//  out_    | out | out_valid / out_ready | knock flags, number, interval, status
//  cfg_    | in  | cfg_wr_en            | cfg_index, cfg_wdata
//
// One beat per clock while out_ready stays high. The input register holds the squared
// magnitude, then decision and state update go into the result register.
// Synchronous active-low reset clears control, state and config to defaults.
// When out_ready is low the input register still takes one more beat.
// ----------------------------------------------------------------------------
module knock_detector_interval_recorder_core (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_valid,
  output logic                               in_ready,
  input  logic                               in_op,
  input  logic signed [kdir_pkg::ACCEL_W-1:0] in_accel_x,
  input  logic signed [kdir_pkg::ACCEL_W-1:0] in_accel_y,
  input  logic signed [kdir_pkg::ACCEL_W-1:0] in_accel_z,
  input  logic [kdir_pkg::TIME_W-1:0]         in_time_ms,
  output logic                               out_valid,
  input  logic                               out_ready,
  output logic                               out_knock_seen,
  output logic                               out_knock_recorded,
  output logic [kdir_pkg::COUNT_W-1:0]        out_knock_number,
  output logic                               out_interval_valid,
  output logic [kdir_pkg::TIME_W-1:0]         out_interval_ms,
  output logic                               out_finished,
  output logic [1:0]                         out_status,
  input  logic                               cfg_wr_en,
  input  logic [kdir_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [kdir_pkg::CFG_W-1:0]          cfg_wdata
);
  import kdir_pkg::*;

  `include "knock_detector_interval_recorder_core_defines.svh"

  cfg_t    cfg_r;
  state_t  st_r;
  state_t  st_nxt;
  result_t res_nxt;
  result_t res_r;

  logic                      s1_valid_r;
  logic                      s1_op_r;
  logic [SQ_W-1:0]           s1_mag_sq_r;
  logic [TIME_W-1:0]         s1_time_r;
  logic                      out_valid_r;

  logic signed [2*ACCEL_W-1:0] sq_x;
  logic signed [2*ACCEL_W-1:0] sq_y;
  logic signed [2*ACCEL_W-1:0] sq_z;
  logic [SQ_W-1:0]             mag_sq;
  logic                        in_fire;
  logic                        advance;

  // squares are non-negative and the sum stays below 2^26
  assign sq_x   = in_accel_x * in_accel_x;
  assign sq_y   = in_accel_y * in_accel_y;
  assign sq_z   = in_accel_z * in_accel_z;
  assign mag_sq = SQ_W'($unsigned(sq_x)) + SQ_W'($unsigned(sq_y))
                + SQ_W'($unsigned(sq_z));

  assign advance  = !out_valid_r || out_ready;
  assign in_ready = !s1_valid_r || advance;
  assign in_fire  = in_valid && in_ready;

  kdir_eval u_eval (
    .op      (s1_op_r),
    .mag_sq  (s1_mag_sq_r),
    .time_ms (s1_time_r),
    .cfg     (cfg_r),
    .st      (st_r),
    .st_nxt  (st_nxt),
    .res     (res_nxt)
  );

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.upper_sq    <= RST_UPPER_SQ;
      cfg_r.lower_sq    <= RST_LOWER_SQ;
      cfg_r.debounce_ms <= RST_DEBOUNCE;
      cfg_r.idle_ms     <= RST_IDLE;
      cfg_r.knock_quota <= RST_KNOCK_QUOTA;
      cfg_r.knock_cap   <= RST_KNOCK_CAP;
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        REG_UPPER_SQ:    cfg_r.upper_sq    <= cfg_wdata[SQ_W-1:0];
        REG_LOWER_SQ:    cfg_r.lower_sq    <= cfg_wdata[SQ_W-1:0];
        REG_DEBOUNCE:    cfg_r.debounce_ms <= cfg_wdata[MS_W-1:0];
        REG_IDLE:        cfg_r.idle_ms     <= cfg_wdata[MS_W-1:0];
        REG_KNOCK_QUOTA: cfg_r.knock_quota <= cfg_wdata[COUNT_W-1:0];
        REG_KNOCK_CAP:   cfg_r.knock_cap   <= cfg_wdata[COUNT_W-1:0];
        default: ;
      endcase
    end
  end

  // control and recorder state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      st_r        <= '0;
    end else begin
      if (in_fire) begin
        s1_valid_r <= 1'b1;
      end else if (advance) begin
        s1_valid_r <= 1'b0;
      end
      if (advance) begin
        out_valid_r <= s1_valid_r;
        if (s1_valid_r) begin
          st_r <= st_nxt;
        end
      end
    end
  end

  // payload
  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_op_r     <= in_op;
      s1_mag_sq_r <= mag_sq;
      s1_time_r   <= in_time_ms;
    end
    if (advance && s1_valid_r) begin
      res_r <= res_nxt;
    end
  end

  assign out_valid          = out_valid_r;
  assign out_knock_seen     = res_r.knock_seen;
  assign out_knock_recorded = res_r.knock_recorded;
  assign out_knock_number   = res_r.knock_number;
  assign out_interval_valid = res_r.interval_valid;
  assign out_interval_ms    = res_r.interval_ms;
  assign out_finished       = res_r.finished;
  assign out_status         = res_r.status;

  `KDIR_ASSERT_IMPL(a_status_on_finish, out_valid_r,
    out_finished == (res_r.status == STATUS_SUCCESS || res_r.status == STATUS_TOO_FEW),
    "status does not match finished flag")

  `KDIR_ASSERT_IMPL(a_interval_needs_record, out_valid_r && out_interval_valid,
    out_knock_recorded && out_knock_seen && (out_knock_number >= COUNT_W'(2)),
    "interval given without a recorded second knock")

  `KDIR_ASSERT_IMPL(a_record_not_finish, out_valid_r && out_knock_seen,
    !out_finished,
    "knock and timeout on the same beat")

  `KDIR_ASSERT_IMPL(a_stop_via_finish, $past(rst_n) && $fell(st_r.recording),
    out_valid_r && out_finished,
    "recording stopped without a finished result")

endmodule

FILE: rtl/kdir_eval.sv
// ----------------------------------------------------------------------------
// Knock detector evaluation
// Threshold, debounce, count and idle-timeout decision for one beat.
// ----------------------------------------------------------------------------
module kdir_eval (
  input  logic                       op,
  input  logic [kdir_pkg::SQ_W-1:0]   mag_sq,
  input  logic [kdir_pkg::TIME_W-1:0] time_ms,
  input  kdir_pkg::cfg_t             cfg,
  input  kdir_pkg::state_t           st,
  output kdir_pkg::state_t           st_nxt,
  output kdir_pkg::result_t          res
);
  import kdir_pkg::*;

  logic [TIME_W-1:0]  since;
  logic               over;
  logic               knock;
  logic               room;
  logic               timeout;
  logic [COUNT_W-1:0] count_inc;

  always_comb begin
    since     = time_ms - st.last_knock_time;
    over      = (mag_sq > cfg.upper_sq) || (mag_sq < cfg.lower_sq);
    knock     = st.recording && over && (since > TIME_W'(cfg.debounce_ms));
    room      = st.knock_count < cfg.knock_cap;
    count_inc = st.knock_count + COUNT_W'(1);
    // a knock restamps the time, so the idle gap is then zero
    timeout   = st.recording && !knock && (since > TIME_W'(cfg.idle_ms));

    st_nxt               = st;
    res.knock_seen       = 1'b0;
    res.knock_recorded   = 1'b0;
    res.knock_number     = st.knock_count;
    res.interval_valid   = 1'b0;
    res.interval_ms      = '0;
    res.finished         = 1'b0;
    res.status           = STATUS_IDLE;

    if (op == OP_START) begin
      st_nxt.recording       = 1'b1;
      st_nxt.knock_count     = '0;
      st_nxt.last_knock_time = time_ms;
      res.knock_number       = '0;
    end else begin
      if (knock) begin
        res.knock_seen         = 1'b1;
        st_nxt.last_knock_time = time_ms;
        if (room) begin
          res.knock_recorded = 1'b1;
          st_nxt.knock_count = count_inc;
          res.knock_number   = count_inc;
          if (st.knock_count != '0) begin
            res.interval_valid = 1'b1;
            res.interval_ms    = since;
          end
        end
      end
      if (timeout) begin
        res.finished     = 1'b1;
        st_nxt.recording = 1'b0;
        res.status       = (st.knock_count >= cfg.knock_quota) ? STATUS_SUCCESS
                                                               : STATUS_TOO_FEW;
      end
    end
  end

endmodule

FILE: verif/knock_detector_interval_recorder_core_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Knock detector interval recorder testbench
// Drives start and sample beats through the valid/ready input with random
// gaps, drains results with random stalls, and checks every result beat,
// field by field, against a cycle-free predictor of the recorder, or against
// the typed result of a directed row. A short directed table comes first,
// then phases of random beats, each phase under its own register setting.
// ----------------------------------------------------------------------------
module knock_detector_interval_recorder_core_tb;
  import kdir_pkg::*;

  localparam int DRAIN_CYCLES  = 6;
  localparam int HOLD_CYCLES   = 80;
  localparam int N_DIRECTED    = 20;
  localparam int N_PHASES      = 10;
  localparam int N_FIXED       = 5;

  localparam logic signed [ACCEL_W-1:0] ACC_MAX = 13'sd4095;
  localparam logic signed [ACCEL_W-1:0] ACC_MIN = 13'h1000;
  localparam logic signed [ACCEL_W-1:0] ACC_1G  = 13'sd256;
  localparam logic signed [ACCEL_W-1:0] ACC_0   = 13'sd0;

  typedef struct packed {
    logic                      op;
    logic signed [ACCEL_W-1:0] ax;
    logic signed [ACCEL_W-1:0] ay;
    logic signed [ACCEL_W-1:0] az;
    logic [TIME_W-1:0]         stamp;
  } knock_beat_t;

  typedef struct packed {
    knock_beat_t beat;
    logic        typed;
    result_t     want;
  } knock_row_t;

  localparam result_t NOTHING = '{1'b0, 1'b0, 8'd0, 1'b0, 32'd0, 1'b0, STATUS_IDLE};

  logic                      clk;
  logic                      rst_n;
  logic                      in_valid;
  logic                      in_ready;
  logic                      in_op;
  logic signed [ACCEL_W-1:0] in_accel_x;
  logic signed [ACCEL_W-1:0] in_accel_y;
  logic signed [ACCEL_W-1:0] in_accel_z;
  logic [TIME_W-1:0]         in_time_ms;
  logic                      out_valid;
  logic                      out_ready;
  logic                      out_knock_seen;
  logic                      out_knock_recorded;
  logic [COUNT_W-1:0]        out_knock_number;
  logic                      out_interval_valid;
  logic [TIME_W-1:0]         out_interval_ms;
  logic                      out_finished;
  logic [1:0]                out_status;
  logic                      cfg_wr_en;
  logic [CFG_IDX_W-1:0]      cfg_index;
  logic [CFG_W-1:0]          cfg_wdata;

  knock_detector_interval_recorder_core dut (.*);

  // predictor copy of the recorder
  cfg_t               knock_cfg;
  logic               rec_active;
  logic [TIME_W-1:0]  last_knock_ms;
  logic [COUNT_W-1:0] knocks_held;

  result_t     expected_q[$];
  int unsigned error_count = 0;
  logic        result_hold_req = 1'b0;
  int unsigned src_gap_max = 0;
  int unsigned src_mode_left = 0;

  // directed beats; typed results are the ones obvious by inspection
  knock_row_t directed_rows [N_DIRECTED] = '{
    // sample before any start: ignored
    '{'{OP_SAMPLE, ACC_MAX, ACC_MIN, ACC_MAX, 32'd100}, 1'b1, NOTHING},
    // start, accel ignored
    '{'{OP_START, ACC_MIN, ACC_MAX, ACC_MIN, 32'd1000}, 1'b1, NOTHING},
    '{'{OP_SAMPLE, ACC_0, ACC_0, ACC_1G, 32'd1010}, 1'b0, NOTHING},
    '{'{OP_SAMPLE, ACC_MAX, ACC_MAX, ACC_MAX, 32'd1200}, 1'b1,
      '{1'b1, 1'b1, 8'd1, 1'b0, 32'd0, 1'b0, STATUS_IDLE}},
    // inside debounce
    '{'{OP_SAMPLE, ACC_MAX, ACC_MAX, ACC_MAX, 32'd1250}, 1'b0, NOTHING},
    // zero magnitude, below the lower bound
    '{'{OP_SAMPLE, ACC_0, ACC_0, ACC_0, 32'd1321}, 1'b1,
      '{1'b1, 1'b1, 8'd2, 1'b1, 32'd121, 1'b0, STATUS_IDLE}},
    // exactly on debounce: not a knock
    '{'{OP_SAMPLE, ACC_0, ACC_0, ACC_0, 32'd1441}, 1'b0, NOTHING},
    '{'{OP_SAMPLE, ACC_MIN, ACC_MIN, ACC_MIN, 32'd1600}, 1'b0, NOTHING},
    // restart mid recording
    '{'{OP_START, ACC_0, ACC_0, ACC_0, 32'd2000}, 1'b1, NOTHING},
    '{'{OP_SAMPLE, ACC_0, ACC_0, ACC_MIN, 32'd2121}, 1'b0, NOTHING},
    // exactly on idle: still recording
    '{'{OP_SAMPLE, ACC_0, -ACC_1G, ACC_0, 32'd7121}, 1'b0, NOTHING},
    '{'{OP_SAMPLE, ACC_1G, ACC_0, ACC_0, 32'd7122}, 1'b1,
      '{1'b0, 1'b0, 8'd1, 1'b0, 32'd0, 1'b1, STATUS_TOO_FEW}},
    // after the finish: count held, nothing else
    '{'{OP_SAMPLE, ACC_MAX, ACC_0, ACC_0, 32'd8000}, 1'b1,
      '{1'b0, 1'b0, 8'd1, 1'b0, 32'd0, 1'b0, STATUS_IDLE}},
    // time wraps past zero
    '{'{OP_START, ACC_0, ACC_0, ACC_0, 32'hFFFF_FF00}, 1'b1, NOTHING},
    '{'{OP_SAMPLE, ACC_0, ACC_0, ACC_MAX, 32'h0000_0010}, 1'b0, NOTHING},
    '{'{OP_SAMPLE, ACC_0, ACC_0, 13'sd10, 32'h0000_0100}, 1'b0, NOTHING},
    '{'{OP_SAMPLE, ACC_0, ACC_MAX, ACC_0, 32'h0000_0200}, 1'b0, NOTHING},
    '{'{OP_SAMPLE, ACC_MAX, ACC_0, ACC_0, 32'h0000_0300}, 1'b0, NOTHING},
    '{'{OP_SAMPLE, ACC_0, ACC_0, ACC_MAX, 32'h0000_0400}, 1'b0, NOTHING},
    '{'{OP_SAMPLE, ACC_0, ACC_0, ACC_1G, 32'h0000_1789}, 1'b1,
      '{1'b0, 1'b0, 8'd5, 1'b0, 32'd0, 1'b1, STATUS_SUCCESS}}
  };

  // register settings for the first phases, extremes among them
  cfg_t fixed_settings [N_FIXED] = '{
    '{26'd86949, 26'd47502, 16'd120, 16'd5000, 8'd5, 8'd30},
    '{26'h3FF_FFFF, 26'd0, 16'd0, 16'd0, 8'd0, 8'd1},
    '{26'd0, 26'h3FF_FFFF, 16'hFFFF, 16'hFFFF, 8'hFF, 8'hFF},
    '{26'd70000, 26'd60000, 16'd20, 16'd300, 8'd3, 8'd4},
    '{26'd86949, 26'd47502, 16'd120, 16'd5000, 8'd5, 8'd0}
  };

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic result_t detect_knock(input knock_beat_t b);
    result_t           r;
    longint            ix, iy, iz, mag_sq;
    logic [TIME_W-1:0] since;
    logic              loud;
    r = NOTHING;
    if (b.op == OP_START) begin
      rec_active    = 1'b1;
      knocks_held   = '0;
      last_knock_ms = b.stamp;
    end else if (rec_active) begin
      ix = b.ax;
      iy = b.ay;
      iz = b.az;
      mag_sq = ix * ix + iy * iy + iz * iz;
      loud = (mag_sq > longint'(knock_cfg.upper_sq)) ||
             (mag_sq < longint'(knock_cfg.lower_sq));
      since = b.stamp - last_knock_ms;
      if (loud && since > TIME_W'(knock_cfg.debounce_ms)) begin
        r.knock_seen = 1'b1;
        if (knocks_held < knock_cfg.knock_cap) begin
          r.knock_recorded = 1'b1;
          if (knocks_held != '0) begin
            r.interval_valid = 1'b1;
            r.interval_ms    = since;
          end
          knocks_held = knocks_held + 8'd1;
        end
        // restamped even when the count is full
        last_knock_ms = b.stamp;
      end
      since = b.stamp - last_knock_ms;
      if (since > TIME_W'(knock_cfg.idle_ms)) begin
        r.finished = 1'b1;
        rec_active = 1'b0;
        r.status   = (knocks_held >= knock_cfg.knock_quota) ? STATUS_SUCCESS : STATUS_TOO_FEW;
      end
    end
    r.knock_number = knocks_held;
    return r;
  endfunction

  task automatic offer_beat(input knock_beat_t b, input logic typed, input result_t want);
    int unsigned gap;
    result_t     predicted;
    if (src_mode_left == 0) begin
      src_gap_max   = ($urandom_range(0, 2) == 0) ? 0 : 19;
      src_mode_left = 40;
    end
    src_mode_left--;
    gap = $urandom_range(0, src_gap_max);
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid   <= 1'b1;
    in_op      <= b.op;
    in_accel_x <= b.ax;
    in_accel_y <= b.ay;
    in_accel_z <= b.az;
    in_time_ms <= b.stamp;
    do @(posedge clk); while (in_ready !== 1'b1);
    predicted = detect_knock(b);
    expected_q.push_back(typed ? want : predicted);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    case (idx)
      REG_UPPER_SQ:    knock_cfg.upper_sq    = val[SQ_W-1:0];
      REG_LOWER_SQ:    knock_cfg.lower_sq    = val[SQ_W-1:0];
      REG_DEBOUNCE:    knock_cfg.debounce_ms = val[MS_W-1:0];
      REG_IDLE:        knock_cfg.idle_ms     = val[MS_W-1:0];
      REG_KNOCK_QUOTA: knock_cfg.knock_quota = val[COUNT_W-1:0];
      REG_KNOCK_CAP:   knock_cfg.knock_cap   = val[COUNT_W-1:0];
      default: ;
    endcase
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    while (expected_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic report_field(input string name, input logic [31:0] want,
                              input logic [31:0] got);
    if (got !== want) begin
      $display("%0t: %s expected %0h, got %0h", $time, name, want, got);
      error_count++;
    end
  endtask

  // result side: random stalls, one long hold on request
  initial begin : result_sink
    int unsigned stall;
    int unsigned sink_gap_max;
    int unsigned sink_mode_left;
    result_t     want;
    sink_gap_max   = 0;
    sink_mode_left = 0;
    out_ready <= 1'b0;
    wait (rst_n === 1'b1);
    @(posedge clk);
    forever begin
      if (result_hold_req) begin
        out_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        result_hold_req = 1'b0;
      end else begin
        if (sink_mode_left == 0) begin
          sink_gap_max   = ($urandom_range(0, 2) == 0) ? 0 : 19;
          sink_mode_left = 40;
        end
        sink_mode_left--;
        stall = $urandom_range(0, sink_gap_max);
        if (stall != 0) begin
          out_ready <= 1'b0;
          repeat (stall) @(posedge clk);
        end
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (out_valid !== 1'b1);
      if (expected_q.size() == 0) begin
        $display("%0t: result beat with nothing outstanding, knock_number %0d",
                 $time, out_knock_number);
        error_count++;
      end else begin
        want = expected_q.pop_front();
        report_field("knock_seen", 32'(want.knock_seen), 32'(out_knock_seen));
        report_field("knock_recorded", 32'(want.knock_recorded), 32'(out_knock_recorded));
        report_field("knock_number", 32'(want.knock_number), 32'(out_knock_number));
        report_field("interval_valid", 32'(want.interval_valid), 32'(out_interval_valid));
        report_field("interval_ms", want.interval_ms, out_interval_ms);
        report_field("finished", 32'(want.finished), 32'(out_finished));
        report_field("status", 32'(want.status), 32'(out_status));
      end
    end
  end

  initial begin : stimulus
    cfg_t        settings;
    knock_beat_t beat;
    int unsigned n_items, roll, knock_pct, start_pct, noise_pct, step;
    logic [TIME_W-1:0] stream_ms;

    rst_n      <= 1'b0;
    in_valid   <= 1'b0;
    in_op      <= OP_START;
    in_accel_x <= '0;
    in_accel_y <= '0;
    in_accel_z <= '0;
    in_time_ms <= '0;
    cfg_wr_en  <= 1'b0;
    cfg_index  <= REG_UPPER_SQ;
    cfg_wdata  <= '0;
    knock_cfg     = '{RST_UPPER_SQ, RST_LOWER_SQ, RST_DEBOUNCE, RST_IDLE,
                      RST_KNOCK_QUOTA, RST_KNOCK_CAP};
    rec_active    = 1'b0;
    last_knock_ms = '0;
    knocks_held   = '0;
    stream_ms     = '0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (directed_rows[r])
      offer_beat(directed_rows[r].beat, directed_rows[r].typed, directed_rows[r].want);
    wait_drained();

    for (int phase = 0; phase < N_PHASES; phase++) begin
      if (phase < N_FIXED) begin
        settings = fixed_settings[phase];
      end else begin
        settings.upper_sq    = SQ_W'($urandom_range(60000, 300000));
        settings.lower_sq    = SQ_W'($urandom_range(0, 65535));
        settings.debounce_ms = MS_W'($urandom_range(0, 400));
        settings.idle_ms     = MS_W'($urandom_range(0, 4000));
        settings.knock_quota = COUNT_W'($urandom_range(0, 12));
        settings.knock_cap   = COUNT_W'($urandom_range(0, 20));
      end
      write_reg(REG_UPPER_SQ, CFG_W'(settings.upper_sq));
      write_reg(REG_LOWER_SQ, CFG_W'(settings.lower_sq));
      write_reg(REG_DEBOUNCE, CFG_W'(settings.debounce_ms));
      write_reg(REG_IDLE, CFG_W'(settings.idle_ms));
      write_reg(REG_KNOCK_QUOTA, CFG_W'(settings.knock_quota));
      write_reg(REG_KNOCK_CAP, CFG_W'(settings.knock_cap));
      cfg_wr_en <= 1'b0;

      // phase 2 knocks on every beat so the count runs into the knock cap
      if (phase == 2) begin
        n_items = 270; knock_pct = 100; start_pct = 0; noise_pct = 0;
      end else begin
        n_items = 85;  knock_pct = 50;  start_pct = 3; noise_pct = 3;
      end

      for (int i = 0; i < n_items; i++) begin
        if (phase == 1 && i == 30) result_hold_req = 1'b1;
        if (phase == 4 && i == 40) wait_drained();

        roll = $urandom_range(0, 99);
        if (roll < noise_pct) begin
          stream_ms = $urandom();
        end else begin
          roll = $urandom_range(0, 99);
          if (roll < knock_pct)
            step = 32'(knock_cfg.debounce_ms) + 1 + $urandom_range(0, 40);
          else if (roll < knock_pct + 6)
            step = 32'(knock_cfg.idle_ms) + 1 + $urandom_range(0, 40);
          else
            step = $urandom_range(0, 32'(knock_cfg.debounce_ms));
          stream_ms = stream_ms + step;
        end

        roll = $urandom_range(0, 99);
        if (roll < 45) begin
          // near 1 g, mostly inside the band
          beat.ax = ACCEL_W'(int'($urandom_range(0, 40)) - 20);
          beat.ay = ACCEL_W'(int'($urandom_range(0, 40)) - 20);
          beat.az = ACCEL_W'(int'($urandom_range(236, 276)));
          if ($urandom_range(0, 1) == 1) beat.az = -beat.az;
        end else if (roll < 60) begin
          // free fall, below the lower bound
          beat.ax = ACCEL_W'(int'($urandom_range(0, 120)) - 60);
          beat.ay = ACCEL_W'(int'($urandom_range(0, 120)) - 60);
          beat.az = ACCEL_W'(int'($urandom_range(0, 120)) - 60);
        end else begin
          beat.ax = ACCEL_W'($urandom_range(0, 8191));
          beat.ay = ACCEL_W'($urandom_range(0, 8191));
          beat.az = ACCEL_W'($urandom_range(0, 8191));
        end

        if (i == 0 || (!rec_active && $urandom_range(0, 1) == 1) ||
            $urandom_range(0, 99) < start_pct)
          beat.op = OP_START;
        else
          beat.op = OP_SAMPLE;
        beat.stamp = stream_ms;
        offer_beat(beat, 1'b0, NOTHING);
      end
      wait_drained();
    end

    if (error_count == 0)
      $display("knock_detector_interval_recorder_core_tb: clean");
    else
      $display("knock_detector_interval_recorder_core_tb: errors");
    $finish;
  end

  initial begin : watchdog
    #5_000_000;
    $display("knock_detector_interval_recorder_core_tb: errors");
    $finish;
  end

endmodule
